// File: hw/rtl/ffba_pkg.sv
package ffba_pkg;

	localparam int POOL_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 16;

	localparam int SIZE_W   = 12;
	localparam int ADDR_W   = 12;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

endpackage

// File: hw/rtl/ffba_ram.sv
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: hw/rtl/first_fit_block_allocator.sv
// first-fit block allocator with coalescing
// input channel s_axis: one beat is one request. tuser carries the opcode
// (0 allocate, 1 free); tdata carries request_size and free_address.
// output channel m_axis: one beat per request with payload_address and
// status (0 done, 1 no fitting block, 2 offset is not a block).
// block headers live in one single-port ram indexed by header byte offset;
// every step of a request is one ram read or write. an allocate walks the
// list from the head and, when the block is split, also writes the new
// block's header and fixes the prv field of the block after it. a free walks
// the list to the freed block, then merges it with its free neighbours. an
// offset below the first header or at the tail is rejected at once; any other
// offset that is not a block is rejected after a walk of the list.
// after reset the block writes the head and tail headers
// and accepts nothing in that time.
// one request is in flight at a time. the result sits in an output register;
// a new request is accepted the cycle after it is loaded, and a finished result
// stalls in the last step until the receiver takes the previous beat.
module first_fit_block_allocator
	import ffba_pkg::*;
#(
	parameter int POOL_BYTES   = POOL_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // request_size[11:0], free_address[23:12]
	input  logic        s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // payload_address[11:0], status[13:12], zero
);

	localparam int AW    = $clog2(POOL_BYTES);
	localparam int LW    = ((AW > SIZE_W) ? AW : SIZE_W) + 2;
	localparam int WALK  = POOL_BYTES / HEADER_BYTES + 2;
	localparam int CW    = $clog2(WALK + 1);
	localparam logic [LW-1:0] HDR  = LW'(HEADER_BYTES);
	localparam logic [LW-1:0] POOL = LW'(POOL_BYTES);
	localparam logic [AW-1:0] TAIL = AW'(POOL_BYTES - HEADER_BYTES);
	localparam logic [AW-1:0] HEAD_LEN = AW'(POOL_BYTES - 2 * HEADER_BYTES);

	typedef struct packed {
		logic [AW-1:0] len;
		logic          free;
		logic [AW-1:0] nxt;
		logic [AW-1:0] prv;
	} hdr_t;

	localparam int HW = $bits(hdr_t);

	typedef enum logic [4:0] {
		S_INIT0, S_INIT1, S_IDLE, S_A_RD, S_A_CHK, S_A_WNB, S_L_RD, S_L_WR,
		S_F_WRD, S_F_WCHK, S_F_GCUR, S_F_GPV, S_F_NX, S_F_GNX, S_DONE
	} state_t;

	state_t              state_q, ret_q;
	logic [AW-1:0]       p_q, cur_q, nb_q, nx_q, len_q, fix_a_q, fix_v_q;
	logic [CW-1:0]       n_q;
	logic [SIZE_W-1:0]   req_q;
	hdr_t                hd_q;
	logic [ADDR_W-1:0]   res_addr_q, out_addr_q;
	logic [STATUS_W-1:0] res_st_q, out_st_q;
	logic                out_valid_q;

	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [HW-1:0]     ram_wdata, ram_rdata;
	hdr_t              rd, wr;
	logic [LW-1:0]     s_w, nb_w, cur_w;
	logic              walk_ok, fits, split, nb_ok;

	ffba_ram #(.WIDTH(HW), .DEPTH(POOL_BYTES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign rd      = hdr_t'(ram_rdata);
	assign ram_wdata = wr;
	assign s_w     = LW'(req_q);
	assign nb_w    = LW'(p_q) + HDR + s_w;
	assign walk_ok = n_q < CW'(WALK);
	assign fits    = rd.free && (LW'(rd.len) >= s_w);
	assign split   = LW'(rd.len) >= (s_w + HDR);
	assign nb_ok   = nb_w < POOL;
	assign cur_w   = LW'(s_axis_tdata[23:12]) - HDR;

	always_comb begin
		ram_we   = 1'b0;
		ram_addr = p_q;
		wr       = '0;
		case (state_q)
			S_INIT0: begin
				ram_we   = 1'b1;
				ram_addr = '0;
				wr       = '{len: HEAD_LEN, free: 1'b1, nxt: TAIL, prv: '0};
			end
			S_INIT1: begin
				ram_we   = 1'b1;
				ram_addr = TAIL;
			end
			S_A_CHK: begin
				if (walk_ok && fits && (!split || nb_ok)) begin
					ram_we = 1'b1;
					if (split) begin
						wr = '{len: AW'(req_q), free: 1'b0, nxt: AW'(nb_w), prv: rd.prv};
					end else begin
						wr = '{len: rd.len, free: 1'b0, nxt: rd.nxt, prv: rd.prv};
					end
				end
			end
			S_A_WNB: begin
				ram_we   = 1'b1;
				ram_addr = nb_q;
				wr       = '{len: len_q, free: 1'b1, nxt: nx_q, prv: p_q};
			end
			S_L_RD: begin
				ram_addr = fix_a_q;
			end
			S_L_WR: begin
				ram_we   = 1'b1;
				ram_addr = fix_a_q;
				wr       = '{len: rd.len, free: rd.free, nxt: rd.nxt, prv: fix_v_q};
			end
			S_F_GCUR: begin
				if (cur_q != '0) begin
					ram_addr = rd.prv;
				end else begin
					ram_we   = 1'b1;
					ram_addr = cur_q;
					wr       = '{len: rd.len, free: 1'b1, nxt: rd.nxt, prv: rd.prv};
				end
			end
			S_F_GPV: begin
				ram_we = 1'b1;
				if (rd.free) begin
					ram_addr = hd_q.prv;
					wr = '{len: AW'(LW'(rd.len) + LW'(hd_q.len) + HDR), free: 1'b1,
						nxt: hd_q.nxt, prv: rd.prv};
				end else begin
					ram_addr = cur_q;
					wr       = hd_q;
				end
			end
			S_F_NX: begin
				ram_addr = hd_q.nxt;
			end
			S_F_GNX: begin
				if (rd.free) begin
					ram_we   = 1'b1;
					ram_addr = cur_q;
					wr = '{len: AW'(LW'(hd_q.len) + LW'(rd.len) + HDR), free: 1'b1,
						nxt: rd.nxt, prv: hd_q.prv};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT0;
			ret_q       <= S_DONE;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT0: state_q <= S_INIT1;
				S_INIT1: state_q <= S_IDLE;
				S_IDLE: begin
					if (s_axis_tvalid) begin
						req_q    <= s_axis_tdata[11:0];
						p_q      <= '0;
						n_q      <= '0;
						res_addr_q <= '0;
						if (s_axis_tuser == OP_ALLOC) begin
							state_q <= S_A_RD;
						end else if (LW'(s_axis_tdata[23:12]) < HDR ||
							cur_w >= LW'(TAIL)) begin
							res_st_q <= ST_BAD;
							state_q  <= S_DONE;
						end else begin
							cur_q   <= AW'(cur_w);
							state_q <= S_F_WRD;
						end
					end
				end
				S_A_RD: state_q <= S_A_CHK;
				S_A_CHK: begin
					if (!walk_ok) begin
						res_st_q <= ST_NOFIT;
						state_q  <= S_DONE;
					end else if (fits) begin
						if (split && !nb_ok) begin
							res_st_q <= ST_NOFIT;
							state_q  <= S_DONE;
						end else begin
							res_st_q   <= ST_DONE;
							res_addr_q <= ADDR_W'(LW'(p_q) + HDR);
							if (split) begin
								nb_q    <= AW'(nb_w);
								nx_q    <= rd.nxt;
								len_q   <= AW'(LW'(rd.len) - s_w - HDR);
								state_q <= S_A_WNB;
							end else begin
								state_q <= S_DONE;
							end
						end
					end else if (p_q == TAIL) begin
						res_st_q <= ST_NOFIT;
						state_q  <= S_DONE;
					end else begin
						p_q     <= rd.nxt;
						n_q     <= n_q + 1'b1;
						state_q <= S_A_RD;
					end
				end
				S_A_WNB: begin
					fix_a_q <= nx_q;
					fix_v_q <= nb_q;
					ret_q   <= S_DONE;
					state_q <= S_L_RD;
				end
				S_L_RD: state_q <= S_L_WR;
				S_L_WR: state_q <= ret_q;
				S_F_WRD: begin
					if (!walk_ok || p_q >= TAIL) begin
						res_st_q <= ST_BAD;
						state_q  <= S_DONE;
					end else if (p_q == cur_q) begin
						res_st_q <= ST_DONE;
						state_q  <= S_F_GCUR;
					end else begin
						state_q <= S_F_WCHK;
					end
				end
				S_F_WCHK: begin
					p_q     <= rd.nxt;
					n_q     <= n_q + 1'b1;
					state_q <= S_F_WRD;
				end
				S_F_GCUR: begin
					hd_q    <= '{len: rd.len, free: 1'b1, nxt: rd.nxt, prv: rd.prv};
					state_q <= (cur_q != '0) ? S_F_GPV : S_F_NX;
				end
				S_F_GPV: begin
					if (rd.free) begin
						hd_q <= '{len: AW'(LW'(rd.len) + LW'(hd_q.len) + HDR), free: 1'b1,
							nxt: hd_q.nxt, prv: rd.prv};
						cur_q   <= hd_q.prv;
						fix_a_q <= hd_q.nxt;
						fix_v_q <= hd_q.prv;
						ret_q   <= S_F_NX;
						state_q <= S_L_RD;
					end else begin
						state_q <= S_F_NX;
					end
				end
				S_F_NX: begin
					state_q <= (hd_q.nxt == TAIL) ? S_DONE : S_F_GNX;
				end
				S_F_GNX: begin
					if (rd.free) begin
						fix_a_q <= rd.nxt;
						fix_v_q <= cur_q;
						ret_q   <= S_DONE;
						state_q <= S_L_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_addr_q  <= (res_st_q == ST_DONE) ? res_addr_q : '0;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_st_q, out_addr_q};

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !ram_we)
		else $error("ram written while idle");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[13:12] != ST_DONE) |-> m_axis_tdata[11:0] == '0)
		else $error("failed request carries an address");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[13:12] == ST_DONE ||
			m_axis_tdata[13:12] == ST_NOFIT || m_axis_tdata[13:12] == ST_BAD))
		else $error("bad status code");

endmodule
